[rtl/core/vector3_alu_macros.svh]
// Assertion macros for the vector3_alu block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef VECTOR3_ALU_MACROS_SVH
`define VECTOR3_ALU_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define V3A_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define V3A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/v3a_pkg.sv]
// Shared codes and widths for the vector3_alu block.
// No dependencies.
package v3a_pkg;

	localparam int FUNC_BITS   = 4;
	localparam int STATUS_BITS = 2;
	localparam int CFG_BITS    = 31;

	localparam logic [CFG_BITS-1:0] MIN_DIV_RESET = CFG_BITS'(1);

	typedef enum logic [FUNC_BITS-1:0] {
		FN_ADD   = 0,
		FN_SUB   = 1,
		FN_NEG   = 2,
		FN_SCALE = 3,
		FN_DIV   = 4,
		FN_DOT   = 5,
		FN_CROSS = 6,
		FN_MAG   = 7,
		FN_UNIT  = 8,
		FN_EQUAL = 9
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 0,
		ST_SMALL = 1,
		ST_SAT   = 2
	} status_t;

endpackage

[rtl/core/v3a_req_if.sv]
// Operation request channel of vector3_alu.
// Depends on v3a_pkg for the opcode width.
interface v3a_req_if #(parameter int WORD_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic [v3a_pkg::FUNC_BITS-1:0]    func;
	logic signed [WORD_BITS-1:0]      a_x;
	logic signed [WORD_BITS-1:0]      a_y;
	logic signed [WORD_BITS-1:0]      a_z;
	logic signed [WORD_BITS-1:0]      b_x;
	logic signed [WORD_BITS-1:0]      b_y;
	logic signed [WORD_BITS-1:0]      b_z;
	logic signed [WORD_BITS-1:0]      scalar_in;

	modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
		input ready);
	modport sink (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
		output ready);
endinterface

[rtl/core/v3a_rsp_if.sv]
// Result channel of vector3_alu.
// Depends on v3a_pkg for the status width.
interface v3a_rsp_if #(parameter int WORD_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic signed [WORD_BITS-1:0]      r_x;
	logic signed [WORD_BITS-1:0]      r_y;
	logic signed [WORD_BITS-1:0]      r_z;
	logic signed [WORD_BITS-1:0]      scalar_out;
	logic                             is_equal;
	logic [v3a_pkg::STATUS_BITS-1:0]  status;

	modport source (output valid, r_x, r_y, r_z, scalar_out, is_equal, status,
		input ready);
	modport sink (input valid, r_x, r_y, r_z, scalar_out, is_equal, status,
		output ready);
endinterface

[rtl/core/v3a_cfg_if.sv]
// Configuration write channel of vector3_alu (min_divisor).
// Depends on v3a_pkg for the register width.
interface v3a_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [v3a_pkg::CFG_BITS-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/core/v3a_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, with sideband.
// No package dependencies.
module v3a_sqrt_pipe #(
	parameter int ROOT_BITS = 32,
	parameter int SIDE_BITS = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [2*ROOT_BITS-1:0]   rad,
	input  logic [SIDE_BITS-1:0]     side_in,
	output logic                     out_valid,
	output logic [ROOT_BITS-1:0]     root,
	output logic [SIDE_BITS-1:0]     side_out
);
	localparam int RB  = ROOT_BITS;
	localparam int RAD = 2 * RB;
	localparam int REM = RB + 1;
	localparam int TW  = RB + 3;

	logic                 v_s    [RB];
	logic [REM-1:0]       rem_s  [RB];
	logic [RB-1:0]        root_s [RB];
	logic [RAD-1:0]       rad_s  [RB];
	logic [SIDE_BITS-1:0] side_s [RB];

	for (genvar k = 0; k < RB; k++) begin : g_stage
		logic                 vi;
		logic [REM-1:0]       rem_i;
		logic [RB-1:0]        root_i;
		logic [RAD-1:0]       rad_i;
		logic [SIDE_BITS-1:0] side_i;
		logic [TW-1:0]        part;
		logic [TW-1:0]        trial;
		logic [TW-1:0]        diff;
		logic                 fits;

		if (k == 0) begin : g_first
			assign vi     = in_valid;
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
			assign side_i = side_in;
		end else begin : g_next
			assign vi     = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign side_i = side_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign part  = {rem_i, rad_i[RAD-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign diff  = part - trial;
		assign fits  = (part >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fits ? diff[REM-1:0] : part[REM-1:0];
				root_s[k] <= {root_i[RB-2:0], fits};
				rad_s[k]  <= rad_i << 2;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[RB-1];
	assign root      = root_s[RB-1];
	assign side_out  = side_s[RB-1];
endmodule

[rtl/core/v3a_div_pipe.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage, several
// lanes sharing one divisor, with sideband. No package dependencies.
module v3a_div_pipe #(
	parameter int LANES     = 3,
	parameter int QUO_BITS  = 48,
	parameter int DVS_BITS  = 32,
	parameter int SIDE_BITS = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [DVS_BITS-1:0]                dvs,
	input  logic [LANES-1:0][QUO_BITS-1:0]     dvd,
	input  logic [SIDE_BITS-1:0]               side_in,
	output logic                               out_valid,
	output logic [LANES-1:0][QUO_BITS-1:0]     quo,
	output logic [SIDE_BITS-1:0]               side_out
);
	localparam int QB = QUO_BITS;
	localparam int DB = DVS_BITS;

	logic                         v_s    [QB];
	logic [DB-1:0]                dvs_s  [QB];
	logic [LANES-1:0][QB-1:0]     nq_s   [QB];
	logic [LANES-1:0][DB-1:0]     rem_s  [QB];
	logic [SIDE_BITS-1:0]         side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic                         vi;
		logic [DB-1:0]                dvs_i;
		logic [LANES-1:0][QB-1:0]     nq_i;
		logic [LANES-1:0][DB-1:0]     rem_i;
		logic [SIDE_BITS-1:0]         side_i;
		logic [LANES-1:0][QB-1:0]     nq_d;
		logic [LANES-1:0][DB-1:0]     rem_d;

		if (k == 0) begin : g_first
			assign vi     = in_valid;
			assign dvs_i  = dvs;
			assign nq_i   = dvd;
			assign rem_i  = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign vi     = v_s[k-1];
			assign dvs_i  = dvs_s[k-1];
			assign nq_i   = nq_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign side_i = side_s[k-1];
		end

		// shift one dividend bit into the remainder, subtract if it fits
		always_comb begin
			logic [DB:0] part;
			logic [DB:0] diff;
			logic        fits;
			for (int l = 0; l < LANES; l++) begin
				part     = {rem_i[l], nq_i[l][QB-1]};
				diff     = part - {1'b0, dvs_i};
				fits     = (part >= {1'b0, dvs_i});
				rem_d[l] = fits ? diff[DB-1:0] : part[DB-1:0];
				nq_d[l]  = {nq_i[l][QB-2:0], fits};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[k]  <= dvs_i;
				nq_s[k]   <= nq_d;
				rem_s[k]  <= rem_d;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign quo       = nq_s[QB-1];
	assign side_out  = side_s[QB-1];
endmodule

[rtl/core/vector3_alu.sv]
// vector3_alu: pipelined 3-component vector ALU in signed fixed point.
// Depends on v3a_pkg, the three channel interfaces, v3a_sqrt_pipe,
// v3a_div_pipe and vector3_alu_macros.svh.
//
//   channel | modport | carries                                   | transfer when
//   --------+---------+-------------------------------------------+------------------
//   req     | sink    | func, a_x..a_z, b_x..b_z, scalar_in       | valid && ready
//   rsp     | source  | r_x..r_z, scalar_out, is_equal, status    | valid && ready
//   cfg     | sink    | data (min_divisor)                        | valid && ready
//
// One item enters per cycle while rsp is not stalled; every item passes through
// the operand stages, the square root stages (one root bit each), the divider
// stages (one quotient bit each) and the output register.
// The whole pipeline advances together; a stalled result on rsp holds every
// stage, and bubbles stay in place, so nothing is lost or repeated.
// Reset clears the valid bits and sets min_divisor to 1; cfg is always ready.
`include "vector3_alu_macros.svh"

module vector3_alu #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	v3a_req_if.sink    req,
	v3a_rsp_if.source  rsp,
	v3a_cfg_if.sink    cfg
);
	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;            // exact product
	localparam int SW = PW + 2;           // sum of three products
	localparam int QB = W + F;            // quotient magnitude
	localparam int CB = v3a_pkg::CFG_BITS;
	localparam int CW = (W > CB) ? W : CB;

	typedef logic signed [W-1:0]  word_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] wide_t;

	localparam wide_t MAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam wide_t MIN_S = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
	localparam logic [QB:0] LIM_P = {{(QB-W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic [QB:0] LIM_N = LIM_P + (QB+1)'(1);

	// sideband carried through the square root stages
	typedef struct packed {
		v3a_pkg::func_t           fn;
		logic [2:0][W-1:0]        r;
		logic [W-1:0]             sc;
		logic                     eq;
		logic                     ovf;
		logic                     err;
		logic [2:0]               neg;
		logic [2:0][QB-1:0]       dvd;
		logic [W-1:0]             dvs;
	} side_t;

	// sideband carried through the divider stages
	typedef struct packed {
		v3a_pkg::func_t           fn;
		logic [2:0][W-1:0]        r;
		logic [W-1:0]             sc;
		logic                     eq;
		logic                     ovf;
		logic                     err;
		logic [2:0]               neg;
	} side2_t;

	function automatic word_t sat_word(wide_t v);
		if (v > MAX_S) begin
			return MAX_S[W-1:0];
		end else if (v < MIN_S) begin
			return MIN_S[W-1:0];
		end
		return v[W-1:0];
	endfunction

	function automatic logic out_range(wide_t v);
		return (v > MAX_S) || (v < MIN_S);
	endfunction

	function automatic logic [W-1:0] abs_word(word_t v);
		return v[W-1] ? ((~v) + W'(1)) : v;
	endfunction

	function automatic logic too_small(logic [W-1:0] m, logic [CB-1:0] lim);
		return CW'(m) <= CW'(lim);
	endfunction

	// ---------------------------------------------------------------
	// Flow control: one enable for every stage and the output register
	// ---------------------------------------------------------------
	logic adv;
	logic out_valid_q;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [CB-1:0] min_div_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_div_q <= v3a_pkg::MIN_DIV_RESET;
		end else if (cfg.valid) begin
			min_div_q <= cfg.data;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: register operands, route multiplier inputs by opcode
	// ---------------------------------------------------------------
	v3a_pkg::func_t fn_d;
	word_t          in_a [3];
	word_t          in_b [3];
	word_t          ma_d [6];
	word_t          mb_d [6];

	assign fn_d    = v3a_pkg::func_t'(req.func);
	assign in_a[0] = req.a_x;
	assign in_a[1] = req.a_y;
	assign in_a[2] = req.a_z;
	assign in_b[0] = req.b_x;
	assign in_b[1] = req.b_y;
	assign in_b[2] = req.b_z;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			ma_d[j] = '0;
			mb_d[j] = '0;
		end
		case (fn_d) inside
			v3a_pkg::FN_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ma_d[i] = in_a[i];
					mb_d[i] = req.scalar_in;
				end
			end
			v3a_pkg::FN_DOT: begin
				for (int i = 0; i < 3; i++) begin
					ma_d[i] = in_a[i];
					mb_d[i] = in_b[i];
				end
			end
			v3a_pkg::FN_CROSS: begin
				// pairs: x = p0 - p1, y = p2 - p3, z = p4 - p5
				ma_d[0] = in_a[1]; mb_d[0] = in_b[2];
				ma_d[1] = in_a[2]; mb_d[1] = in_b[1];
				ma_d[2] = in_a[2]; mb_d[2] = in_b[0];
				ma_d[3] = in_a[0]; mb_d[3] = in_b[2];
				ma_d[4] = in_a[0]; mb_d[4] = in_b[1];
				ma_d[5] = in_a[1]; mb_d[5] = in_b[0];
			end
			v3a_pkg::FN_MAG, v3a_pkg::FN_UNIT: begin
				for (int i = 0; i < 3; i++) begin
					ma_d[i] = in_a[i];
					mb_d[i] = in_a[i];
				end
			end
			default: begin
			end
		endcase
	end

	logic           v_s1;
	v3a_pkg::func_t fn_s1;
	word_t          a_s1 [3];
	word_t          b_s1 [3];
	word_t          s_s1;
	word_t          ma_s1 [6];
	word_t          mb_s1 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fn_s1 <= fn_d;
			s_s1  <= req.scalar_in;
			a_s1  <= in_a;
			b_s1  <= in_b;
			ma_s1 <= ma_d;
			mb_s1 <= mb_d;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: six multipliers; add, subtract, negate and compare
	// ---------------------------------------------------------------
	word_t rv_d [3];
	logic  ovf2_d;
	logic  eq_d;

	always_comb begin
		wide_t t;
		ovf2_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			case (fn_s1)
				v3a_pkg::FN_ADD: t = wide_t'(a_s1[i]) + wide_t'(b_s1[i]);
				v3a_pkg::FN_SUB: t = wide_t'(a_s1[i]) - wide_t'(b_s1[i]);
				v3a_pkg::FN_NEG: t = -wide_t'(a_s1[i]);
				default:         t = '0;
			endcase
			rv_d[i] = sat_word(t);
			ovf2_d  = ovf2_d | out_range(t);
		end
		eq_d = (fn_s1 == v3a_pkg::FN_EQUAL) && (a_s1[0] == b_s1[0]) &&
			(a_s1[1] == b_s1[1]) && (a_s1[2] == b_s1[2]);
	end

	logic           v_s2;
	v3a_pkg::func_t fn_s2;
	prod_t          p_s2 [6];
	word_t          rv_s2 [3];
	logic           ovf_s2;
	logic           eq_s2;
	word_t          a_s2 [3];
	word_t          s_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 6; j++) begin
				p_s2[j] <= PW'(ma_s1[j]) * PW'(mb_s1[j]);
			end
			fn_s2  <= fn_s1;
			rv_s2  <= rv_d;
			ovf_s2 <= ovf2_d;
			eq_s2  <= eq_d;
			a_s2   <= a_s1;
			s_s2   <= s_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: sum products, drop fraction bits (floor), saturate;
	// prepare radicand and divider operands
	// ---------------------------------------------------------------
	side_t         side_d;
	logic [PW-1:0] rad_d;

	always_comb begin
		wide_t         e [6];
		wide_t         sum3;
		wide_t         dif [3];
		logic [W-1:0]  sab;
		for (int j = 0; j < 6; j++) begin
			e[j] = wide_t'(p_s2[j]);
		end
		sum3   = e[0] + e[1] + e[2];
		dif[0] = e[0] - e[1];
		dif[1] = e[2] - e[3];
		dif[2] = e[4] - e[5];
		sab    = abs_word(s_s2);

		side_d     = '0;
		side_d.fn  = fn_s2;
		side_d.eq  = eq_s2;
		side_d.dvs = sab;
		rad_d      = sum3[PW-1:0];
		for (int i = 0; i < 3; i++) begin
			side_d.dvd[i] = QB'(abs_word(a_s2[i])) << F;
			side_d.neg[i] = a_s2[i][W-1];
		end

		case (fn_s2) inside
			v3a_pkg::FN_ADD, v3a_pkg::FN_SUB, v3a_pkg::FN_NEG: begin
				for (int i = 0; i < 3; i++) begin
					side_d.r[i] = rv_s2[i];
				end
				side_d.ovf = ovf_s2;
			end
			v3a_pkg::FN_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					side_d.r[i] = sat_word(e[i] >>> F);
					side_d.ovf  = side_d.ovf | out_range(e[i] >>> F);
				end
			end
			v3a_pkg::FN_DOT: begin
				side_d.sc  = sat_word(sum3 >>> F);
				side_d.ovf = out_range(sum3 >>> F);
			end
			v3a_pkg::FN_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					side_d.r[i] = sat_word(dif[i] >>> F);
					side_d.ovf  = side_d.ovf | out_range(dif[i] >>> F);
				end
			end
			v3a_pkg::FN_DIV: begin
				side_d.err = too_small(sab, min_div_q);
				for (int i = 0; i < 3; i++) begin
					side_d.neg[i] = a_s2[i][W-1] ^ s_s2[W-1];
				end
			end
			default: begin
			end
		endcase
	end

	logic          v_s3;
	side_t         side_s3;
	logic [PW-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_d;
			rad_s3  <= rad_d;
		end
	end

	// ---------------------------------------------------------------
	// Square root of the sum of squares (magnitude already in Q format)
	// ---------------------------------------------------------------
	logic                     sq_valid;
	logic [W-1:0]             sq_root;
	logic [$bits(side_t)-1:0] sq_side_raw;
	side_t                    sq_side;

	v3a_sqrt_pipe #(
		.ROOT_BITS (W),
		.SIDE_BITS ($bits(side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.side_in   (side_s3),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side_raw)
	);

	assign sq_side = side_t'(sq_side_raw);

	// magnitude result, and the divisor and range check for unit
	side2_t        dv_side;
	logic [W-1:0]  dv_dvs;

	always_comb begin
		dv_side.fn  = sq_side.fn;
		dv_side.r   = sq_side.r;
		dv_side.sc  = sq_side.sc;
		dv_side.eq  = sq_side.eq;
		dv_side.ovf = sq_side.ovf;
		dv_side.err = sq_side.err;
		dv_side.neg = sq_side.neg;
		dv_dvs      = sq_side.dvs;
		case (sq_side.fn)
			v3a_pkg::FN_MAG: begin
				dv_side.sc  = sq_root[W-1] ? MAX_W : sq_root;
				dv_side.ovf = sq_root[W-1];
			end
			v3a_pkg::FN_UNIT: begin
				dv_dvs      = sq_root;
				dv_side.err = too_small(sq_root, min_div_q);
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Divider: |A| << FRAC_BITS over |scalar| or the magnitude
	// ---------------------------------------------------------------
	logic                      dq_valid;
	logic [2:0][QB-1:0]        dq_quo;
	logic [$bits(side2_t)-1:0] dq_side_raw;
	side2_t                    dq_side;

	v3a_div_pipe #(
		.LANES     (3),
		.QUO_BITS  (QB),
		.DVS_BITS  (W),
		.SIDE_BITS ($bits(side2_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.dvs       (dv_dvs),
		.dvd       (sq_side.dvd),
		.side_in   (dv_side),
		.out_valid (dq_valid),
		.quo       (dq_quo),
		.side_out  (dq_side_raw)
	);

	assign dq_side = side2_t'(dq_side_raw);

	// ---------------------------------------------------------------
	// Output stage: apply quotient sign, saturate, drop on small divisor
	// ---------------------------------------------------------------
	logic [2:0][W-1:0]            r_d;
	logic [W-1:0]                 sc_d;
	logic                         eq_o_d;
	v3a_pkg::status_t             st_d;

	always_comb begin
		logic [QB:0] qx;
		logic        ovf;
		logic        quot_op;
		ovf     = dq_side.ovf;
		sc_d    = dq_side.sc;
		eq_o_d  = dq_side.eq;
		quot_op = (dq_side.fn == v3a_pkg::FN_DIV) || (dq_side.fn == v3a_pkg::FN_UNIT);
		for (int i = 0; i < 3; i++) begin
			r_d[i] = dq_side.r[i];
			qx     = {1'b0, dq_quo[i]};
			if (quot_op) begin
				if (dq_side.neg[i]) begin
					if (qx > LIM_N) begin
						r_d[i] = MIN_W;
						ovf    = 1'b1;
					end else begin
						r_d[i] = (~dq_quo[i][W-1:0]) + W'(1);
					end
				end else begin
					if (qx > LIM_P) begin
						r_d[i] = MAX_W;
						ovf    = 1'b1;
					end else begin
						r_d[i] = dq_quo[i][W-1:0];
					end
				end
			end
		end
		if (dq_side.err) begin
			r_d  = '0;
			sc_d = '0;
			st_d = v3a_pkg::ST_SMALL;
		end else if (ovf) begin
			st_d = v3a_pkg::ST_SAT;
		end else begin
			st_d = v3a_pkg::ST_OK;
		end
	end

	logic [2:0][W-1:0] r_q;
	logic [W-1:0]      sc_q;
	logic              eq_q;
	v3a_pkg::status_t  st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_q  <= r_d;
			sc_q <= sc_d;
			eq_q <= eq_o_d;
			st_q <= st_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.r_x        = r_q[0];
	assign rsp.r_y        = r_q[1];
	assign rsp.r_z        = r_q[2];
	assign rsp.scalar_out = sc_q;
	assign rsp.is_equal   = eq_q;
	assign rsp.status     = st_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	logic rsp_small;
	logic rsp_zero;
	logic rsp_stall;

	assign rsp_small = rsp.valid && (rsp.status == v3a_pkg::ST_SMALL);
	assign rsp_zero  = (rsp.r_x == '0) && (rsp.r_y == '0) && (rsp.r_z == '0) &&
		(rsp.scalar_out == '0);
	assign rsp_stall = rsp.valid && !rsp.ready;

	`V3A_ASSERT_SAME(a_small_zero, rsp_small, rsp_zero, "small divisor result not zero")
	`V3A_ASSERT_SAME(a_eq_ok, rsp.valid && rsp.is_equal, rsp.status == v3a_pkg::ST_OK, "eq flag bad")
	`V3A_ASSERT_SAME(a_stall_holds_entry, rsp_stall, !req.ready, "request taken while stalled")
	`V3A_ASSERT_NEXT(a_stall_keeps_result, rsp_stall, $stable(r_q) && $stable(st_q), "stall moved")
endmodule
